@@ rtl/core/pfnw_pkg.sv @@
// shared constants, types and codes for the per-flow newest-wins filter
package pfnw_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int MAX_DATAGRAM = 1024;
    localparam int HEADER_BYTES = 9;

    localparam int IDX_W   = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(FLOW_ENTRIES + 1);
    localparam int OID_W   = 32;
    localparam int COMP_W  = 8;
    localparam int KEY_W   = OID_W + COMP_W;
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 16;
    localparam int BYTES_W = 11;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_TRUNC     = 3'd2,
        VERDICT_STALE     = 3'd3,
        VERDICT_UNTRACKED = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] seq;
    } flow_entry_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        flow_entry_t       wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic too_short;
        logic truncated;
    } hdr_status_t;

    typedef struct packed {
        logic [CNT_W-1:0] flows_used;
        logic             searching;
    } ctrl_status_t;

    // true when incoming is ahead of previous by 1..32767 modulo 2^16
    function automatic logic seq_is_newer(input logic [SEQ_W-1:0] incoming,
                                          input logic [SEQ_W-1:0] previous);
        logic [SEQ_W-1:0] seq_delta;
        seq_delta = incoming - previous;
        return (seq_delta != '0) && !seq_delta[SEQ_W-1];
    endfunction

endpackage

@@ rtl/core/per_flow_newest_wins_filter.sv @@
// top level of the per-flow newest-wins datagram filter
//
// one request per datagram header: drive object_id, component, sequence_req,
// payload_length and datagram_bytes with start high; the request is taken at
// a rising edge where start is high and busy is low.
// one result per request: done pulses for a single cycle with verdict and the
// echoed object id, component and length (zero for short, truncated and stale datagrams).
// a datagram failing the length checks, or the first flow into an
// empty table, gets its result in the cycle after the request.
// otherwise the flow table memory is scanned one entry per cycle through its
// single registered read port; a match ends the scan early.
// busy is high while the scan runs; a new request can be taken in the cycle
// done is high.
// reset clears the fill count, so the table reads as empty with no clearing
// pass; entries are written in order and only those below the count are read.
// the receiver cannot stall: a result not taken in its done cycle is gone.
module per_flow_newest_wins_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pfnw_pkg::OID_W-1:0]   object_id,
    input  logic [pfnw_pkg::COMP_W-1:0]  component,
    input  logic [pfnw_pkg::SEQ_W-1:0]   sequence_req,
    input  logic [pfnw_pkg::LEN_W-1:0]   payload_length,
    input  logic [pfnw_pkg::BYTES_W-1:0] datagram_bytes,
    output logic                         done,
    output pfnw_pkg::verdict_t           verdict,
    output logic [pfnw_pkg::OID_W-1:0]   out_object_id,
    output logic [pfnw_pkg::COMP_W-1:0]  out_component,
    output logic [pfnw_pkg::LEN_W-1:0]   out_length
);
    import pfnw_pkg::*;

    hdr_status_t  hdr;
    ram_req_t     req;
    flow_entry_t  rdata;
    ctrl_status_t status;

    pfnw_hdr_check u_hdr_check (
        .payload_length (payload_length),
        .datagram_bytes (datagram_bytes),
        .status         (hdr)
    );

    pfnw_flow_ram u_flow_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    pfnw_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .object_id      (object_id),
        .component      (component),
        .sequence_req   (sequence_req),
        .payload_length (payload_length),
        .hdr            (hdr),
        .rdata          (rdata),
        .req            (req),
        .busy           (busy),
        .done           (done),
        .verdict        (verdict),
        .out_object_id  (out_object_id),
        .out_component  (out_component),
        .out_length     (out_length),
        .status         (status)
    );

    // result cycle always frees the block for the next request
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // a datagram under the header size is rejected in the cycle after the request
    a_short_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && datagram_bytes < BYTES_W'(HEADER_BYTES))
        |=> (done && verdict == VERDICT_SHORT))
        else $error("short datagram not rejected on time");

    // rejected datagrams carry zero payload fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict != VERDICT_ACCEPT && verdict != VERDICT_UNTRACKED)
        |-> (out_object_id == '0 && out_component == '0 && out_length == '0))
        else $error("rejected datagram with nonzero fields");

    // untracked only when the table is full, and the count never overruns
    a_untracked_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict == VERDICT_UNTRACKED)
        |-> status.flows_used == CNT_W'(FLOW_ENTRIES))
        else $error("untracked verdict with free table entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.flows_used <= CNT_W'(FLOW_ENTRIES))
        else $error("flow count beyond table size");

endmodule

@@ rtl/core/pfnw_hdr_check.sv @@
// header length checks: clamp received byte count, flag short and truncated datagrams
module pfnw_hdr_check (
    input  logic [pfnw_pkg::LEN_W-1:0]   payload_length,
    input  logic [pfnw_pkg::BYTES_W-1:0] datagram_bytes,
    output pfnw_pkg::hdr_status_t        status
);
    import pfnw_pkg::*;

    logic [BYTES_W-1:0] bytes_clamped;
    logic [LEN_W:0]     needed;
    logic [LEN_W:0]     have;

    always_comb
    begin
        if (datagram_bytes > BYTES_W'(MAX_DATAGRAM))
        begin
            bytes_clamped = BYTES_W'(MAX_DATAGRAM);
        end
        else
        begin
            bytes_clamped = datagram_bytes;
        end
        needed           = {1'b0, payload_length} + (LEN_W+1)'(HEADER_BYTES);
        have             = (LEN_W+1)'(bytes_clamped);
        status.too_short = bytes_clamped < BYTES_W'(HEADER_BYTES);
        status.truncated = needed > have;
    end

endmodule

@@ rtl/core/pfnw_flow_ram.sv @@
// flow table memory: one write port, one registered read port
module pfnw_flow_ram (
    input  logic                  clk,
    input  pfnw_pkg::ram_req_t    req,
    output pfnw_pkg::flow_entry_t rdata
);
    import pfnw_pkg::*;

    flow_entry_t mem [FLOW_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ rtl/core/pfnw_ctrl.sv @@
// request sequencer: flow table scan, sequence update, new flow insert, result register
module pfnw_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pfnw_pkg::OID_W-1:0]   object_id,
    input  logic [pfnw_pkg::COMP_W-1:0]  component,
    input  logic [pfnw_pkg::SEQ_W-1:0]   sequence_req,
    input  logic [pfnw_pkg::LEN_W-1:0]   payload_length,
    input  pfnw_pkg::hdr_status_t        hdr,
    input  pfnw_pkg::flow_entry_t        rdata,
    output pfnw_pkg::ram_req_t           req,
    output logic                         busy,
    output logic                         done,
    output pfnw_pkg::verdict_t           verdict,
    output logic [pfnw_pkg::OID_W-1:0]   out_object_id,
    output logic [pfnw_pkg::COMP_W-1:0]  out_component,
    output logic [pfnw_pkg::LEN_W-1:0]   out_length,
    output pfnw_pkg::ctrl_status_t       status
);
    import pfnw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              pending_reg, pending_next;
    logic              issued_reg, issued_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              done_reg, done_next;
    verdict_t          verdict_reg, verdict_next;
    logic [OID_W-1:0]  oid_out_reg, oid_out_next;
    logic [COMP_W-1:0] comp_out_reg, comp_out_next;
    logic [LEN_W-1:0]  len_out_reg, len_out_next;

    logic [CNT_W-1:0]  last_idx;
    logic              table_full;
    logic              hit;

    assign last_idx   = used_reg - CNT_W'(1);
    assign table_full = used_reg == CNT_W'(FLOW_ENTRIES);
    assign hit        = rdata.key == key_reg;

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        scan_next     = scan_reg;
        cmp_idx_next  = cmp_idx_reg;
        pending_next  = 1'b0;
        issued_next   = issued_reg;
        key_next      = key_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        done_next     = 1'b0;
        verdict_next  = verdict_reg;
        oid_out_next  = oid_out_reg;
        comp_out_next = comp_out_reg;
        len_out_next  = len_out_reg;
        req           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = {object_id, component};
                    seq_next = sequence_req;
                    len_next = payload_length;
                    if (hdr.too_short || hdr.truncated)
                    begin
                        done_next     = 1'b1;
                        verdict_next  = hdr.too_short ? VERDICT_SHORT : VERDICT_TRUNC;
                        oid_out_next  = '0;
                        comp_out_next = '0;
                        len_out_next  = '0;
                    end
                    else if (used_reg == '0)
                    begin
                        // empty table: record the flow right away
                        req.we        = 1'b1;
                        req.waddr     = '0;
                        req.wdata.key = {object_id, component};
                        req.wdata.seq = sequence_req;
                        used_next     = used_reg + CNT_W'(1);
                        done_next     = 1'b1;
                        verdict_next  = VERDICT_ACCEPT;
                        oid_out_next  = object_id;
                        comp_out_next = component;
                        len_out_next  = payload_length;
                    end
                    else
                    begin
                        state_next  = ST_SEARCH;
                        scan_next   = '0;
                        issued_next = 1'b0;
                    end
                end
            end

            ST_SEARCH:
            begin
                // one read issued per cycle, each compared in the cycle after its read
                if (!issued_reg)
                begin
                    req.re       = 1'b1;
                    req.raddr    = scan_reg;
                    pending_next = 1'b1;
                    cmp_idx_next = scan_reg;
                    if ({1'b0, scan_reg} == last_idx)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + IDX_W'(1);
                    end
                end

                if (pending_reg)
                begin
                    if (hit)
                    begin
                        state_next    = ST_IDLE;
                        pending_next  = 1'b0;
                        done_next     = 1'b1;
                        if (seq_is_newer(seq_reg, rdata.seq))
                        begin
                            req.we        = 1'b1;
                            req.waddr     = cmp_idx_reg;
                            req.wdata.key = key_reg;
                            req.wdata.seq = seq_reg;
                            verdict_next  = VERDICT_ACCEPT;
                            oid_out_next  = key_reg[KEY_W-1:COMP_W];
                            comp_out_next = key_reg[COMP_W-1:0];
                            len_out_next  = len_reg;
                        end
                        else
                        begin
                            verdict_next  = VERDICT_STALE;
                            oid_out_next  = '0;
                            comp_out_next = '0;
                            len_out_next  = '0;
                        end
                    end
                    else if ({1'b0, cmp_idx_reg} == last_idx)
                    begin
                        state_next    = ST_IDLE;
                        pending_next  = 1'b0;
                        done_next     = 1'b1;
                        oid_out_next  = key_reg[KEY_W-1:COMP_W];
                        comp_out_next = key_reg[COMP_W-1:0];
                        len_out_next  = len_reg;
                        if (table_full)
                        begin
                            verdict_next = VERDICT_UNTRACKED;
                        end
                        else
                        begin
                            req.we        = 1'b1;
                            req.waddr     = used_reg[IDX_W-1:0];
                            req.wdata.key = key_reg;
                            req.wdata.seq = seq_reg;
                            used_next     = used_reg + CNT_W'(1);
                            verdict_next  = VERDICT_ACCEPT;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            pending_reg  <= 1'b0;
            issued_reg   <= 1'b0;
            done_reg     <= 1'b0;
            scan_reg     <= '0;
            cmp_idx_reg  <= '0;
            verdict_reg  <= VERDICT_ACCEPT;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            pending_reg  <= pending_next;
            issued_reg   <= issued_next;
            done_reg     <= done_next;
            scan_reg     <= scan_next;
            cmp_idx_reg  <= cmp_idx_next;
            verdict_reg  <= verdict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        seq_reg      <= seq_next;
        len_reg      <= len_next;
        oid_out_reg  <= oid_out_next;
        comp_out_reg <= comp_out_next;
        len_out_reg  <= len_out_next;
    end

    assign busy             = state_reg != ST_IDLE;
    assign done             = done_reg;
    assign verdict          = verdict_reg;
    assign out_object_id    = oid_out_reg;
    assign out_component    = comp_out_reg;
    assign out_length       = len_out_reg;
    assign status.flows_used = used_reg;
    assign status.searching  = state_reg == ST_SEARCH;

endmodule
